/* rtl/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/kti_pkg.sv */
// ----------------------------------------------------------------------------
// kti_pkg
// Types and constants of the keyframe track interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kti_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_EVAL   = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    SRC_STATIC  = 2'd0,
    SRC_DEFAULT = 2'd1,
    SRC_HELD    = 2'd2,
    SRC_BLEND   = 2'd3
  } src_e;

  typedef enum logic [1:0] {
    MODE_STEP    = 2'd0,
    MODE_LINEAR  = 2'd1,
    MODE_HERMITE = 2'd2,
    MODE_BEZIER  = 2'd3
  } mode_e;

  localparam logic [2:0] REG_MODE       = 3'd0;
  localparam logic [2:0] REG_STATIC_XY  = 3'd1;
  localparam logic [2:0] REG_STATIC_ZW  = 3'd2;
  localparam logic [2:0] REG_DEFAULT_XY = 3'd3;
  localparam logic [2:0] REG_DEFAULT_ZW = 3'd4;

  localparam int unsigned WEIGHT_W = 18;
  localparam int unsigned ACC_W    = 52;

  localparam logic signed [ACC_W-1:0] Q48_ONE = 52'sh1000000000000;
  localparam logic signed [ACC_W-1:0] RND32   = 52'sh0000080000000;
  localparam logic signed [ACC_W-1:0] RND16   = 52'sh0000000008000;
  localparam logic signed [ACC_W-1:0] SAT_MAX = 52'sh000007FFFFFFF;
  localparam logic signed [ACC_W-1:0] SAT_MIN = -52'sh000080000000;

  typedef logic signed [WEIGHT_W-1:0] weight_t;

  typedef struct packed {
    logic [1:0]         command;
    logic signed [31:0] sample_time;
    logic signed [31:0] interval_start;
    logic signed [31:0] interval_end;
    logic [63:0]        value_xy;
    logic [63:0]        value_zw;
    logic [63:0]        in_tan_xy;
    logic [63:0]        in_tan_zw;
    logic [63:0]        out_tan_xy;
    logic [63:0]        out_tan_zw;
  } kti_in_t;

  typedef struct packed {
    logic [63:0] result_xy;
    logic [63:0] result_zw;
    src_e        source;
  } kti_out_t;

  // components packed {w, z, y, x}
  typedef struct packed {
    logic signed [31:0] key_time;
    logic [127:0]       value;
    logic [127:0]       in_tan;
    logic [127:0]       out_tan;
  } key_t;

  typedef struct packed {
    logic        start;
    logic [31:0] num;
    logic [31:0] den;
    mode_e       mode;
  } wgt_req_t;

  typedef struct packed {
    logic    clr;
    logic    en;
    weight_t wt;
  } lane_ctl_t;

endpackage

/* rtl/kti_key_store.sv */
// ----------------------------------------------------------------------------
// kti_key_store
// Key table: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kti_key_store #(
  parameter int unsigned MAX_KEYS = 64
) (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [$clog2(MAX_KEYS)-1:0] wr_addr_i,
  input  kti_pkg::key_t               wr_key_i,
  input  logic [$clog2(MAX_KEYS)-1:0] rd_addr_i,
  output kti_pkg::key_t               rd_key_o
);
  import kti_pkg::*;

  key_t mem [MAX_KEYS];
  key_t rd_key_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_key_q <= mem[rd_addr_i];
  end

  assign rd_key_o = rd_key_q;

endmodule

/* rtl/kti_weight_unit.sv */
// ----------------------------------------------------------------------------
// kti_weight_unit
// Blend factor by 16-step restoring division, then the four key weights.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kti_weight_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  kti_pkg::wgt_req_t req_i,
  output logic              done_o,
  output kti_pkg::weight_t  weight_o [4]
);
  import kti_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DIV  = 3'd1;
  localparam logic [2:0] S_MUL1 = 3'd2;
  localparam logic [2:0] S_MUL2 = 3'd3;
  localparam logic [2:0] S_WGT  = 3'd4;

  logic [2:0]  state_q, state_d;
  logic [3:0]  step_q, step_d;
  logic        done_q, done_d;
  logic [31:0] rem_q;
  logic [31:0] den_q;
  logic [15:0] quo_q;
  mode_e       mode_q;
  logic [31:0] f2_q;
  logic [32:0] g2_q;
  logic [47:0] f3_q;
  logic [48:0] g3_q, fg2_q, f2g_q;
  weight_t     w_q [4];
  weight_t     w_d [4];

  logic [32:0] rem_sh;
  logic        q_bit;
  logic [16:0] f_val, g_val;

  logic signed [ACC_W-1:0] fs, f2s, f3s, g3s, fg2s, f2gs;
  logic signed [ACC_W-1:0] cub [4];
  logic signed [ACC_W-1:0] cub_r [4];

  assign rem_sh = {rem_q, 1'b0};
  assign q_bit  = (rem_sh >= {1'b0, den_q});
  assign f_val  = {1'b0, quo_q};
  assign g_val  = 17'h10000 - f_val;

  assign fs   = $signed(ACC_W'(quo_q));
  assign f2s  = $signed(ACC_W'(f2_q));
  assign f3s  = $signed(ACC_W'(f3_q));
  assign g3s  = $signed(ACC_W'(g3_q));
  assign fg2s = $signed(ACC_W'(fg2_q));
  assign f2gs = $signed(ACC_W'(f2g_q));

  always_comb begin
    if (mode_q == MODE_HERMITE) begin
      cub[0] = (f3s <<< 1) - (f2s <<< 16) - (f2s <<< 17) + Q48_ONE;
      cub[1] = f3s - (f2s <<< 17) + (fs <<< 32);
      cub[2] = f3s - (f2s <<< 16);
      cub[3] = (f2s <<< 16) + (f2s <<< 17) - (f3s <<< 1);
    end else begin
      cub[0] = g3s;
      cub[1] = fg2s + (fg2s <<< 1);
      cub[2] = f2gs + (f2gs <<< 1);
      cub[3] = f3s;
    end
    for (int i = 0; i < 4; i++) begin
      cub_r[i] = (cub[i] + RND32) >>> 32;
    end
    if (mode_q == MODE_LINEAR) begin
      w_d[0] = weight_t'({1'b0, g_val});
      w_d[1] = '0;
      w_d[2] = '0;
      w_d[3] = weight_t'({1'b0, f_val});
    end else begin
      for (int i = 0; i < 4; i++) begin
        w_d[i] = cub_r[i][WEIGHT_W-1:0];
      end
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    done_d  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (req_i.start) begin
          state_d = S_DIV;
          step_d  = '0;
        end
      end
      S_DIV: begin
        step_d = step_q + 4'd1;
        if (step_q == 4'd15) begin
          state_d = S_MUL1;
        end
      end
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_WGT;
      S_WGT: begin
        state_d = S_IDLE;
        done_d  = 1'b1;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_i.start) begin
      rem_q  <= req_i.num;
      den_q  <= req_i.den;
      quo_q  <= '0;
      mode_q <= req_i.mode;
    end
    if (state_q == S_DIV) begin
      rem_q <= q_bit ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
      quo_q <= {quo_q[14:0], q_bit};
    end
    if (state_q == S_MUL1) begin
      f2_q <= {16'd0, quo_q} * {16'd0, quo_q};
      g2_q <= 33'(34'(g_val) * 34'(g_val));
    end
    if (state_q == S_MUL2) begin
      f3_q  <= 48'({16'd0, f2_q} * {32'd0, quo_q});
      g3_q  <= 49'({17'd0, g2_q} * {33'd0, g_val});
      fg2_q <= 49'({17'd0, g2_q} * {34'd0, quo_q});
      f2g_q <= 49'({18'd0, f2_q} * {33'd0, g_val});
    end
    if (state_q == S_WGT) begin
      w_q <= w_d;
    end
  end

  assign done_o   = done_q;
  assign weight_o = w_q;

endmodule

/* rtl/kti_lane.sv */
// ----------------------------------------------------------------------------
// kti_lane
// One component lane: multiply-accumulate over the four operands, then
// round to Q16.16 and saturate.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kti_lane (
  input  logic               clk_i,
  input  kti_pkg::lane_ctl_t ctl_i,
  input  logic signed [31:0] operand_i,
  output logic [31:0]        result_o
);
  import kti_pkg::*;

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [49:0]      prod;
  logic signed [ACC_W-1:0] scaled;

  assign prod = operand_i * ctl_i.wt;

  always_comb begin
    acc_d = acc_q;
    if (ctl_i.clr) begin
      acc_d = '0;
    end else if (ctl_i.en) begin
      acc_d = acc_q + ACC_W'(prod);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  assign scaled = (acc_q + RND16) >>> 16;

  always_comb begin
    if (scaled > SAT_MAX) begin
      result_o = 32'h7fff_ffff;
    end else if (scaled < SAT_MIN) begin
      result_o = 32'h8000_0000;
    end else begin
      result_o = scaled[31:0];
    end
  end

endmodule

/* rtl/keyframe_track_interpolator.sv */
// ----------------------------------------------------------------------------
// keyframe_track_interpolator
// Animation key table with step, linear, Hermite and Bezier evaluation.
// ----------------------------------------------------------------------------
// Clear and append are handled without leaving the idle state. An evaluate
// against the static value answers in the cycle after it is taken. Otherwise
// the key table, a single read port, is scanned one key at a time, each key
// taking a read state and a compare state; a blend then waits on the
// bit-serial divider that forms the blend factor and on the four component
// lanes stepping through their operands. busy is high for the whole of a
// scanning evaluate; the result word is on result_o for the single cycle that
// done_o is high and must be taken then.
`timescale 1ns / 1ps

module keyframe_track_interpolator #(
  parameter int unsigned MAX_KEYS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  kti_pkg::kti_in_t  item_i,
  output logic              busy,
  output logic              done_o,
  output kti_pkg::kti_out_t result_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [5:0]        paddr,
  input  logic [63:0]       pwdata,
  output logic [63:0]       prdata,
  output logic              pready
);
  import kti_pkg::*;

  localparam int unsigned IW = $clog2(MAX_KEYS);
  localparam int unsigned CW = $clog2(MAX_KEYS + 1);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_SCAN_RD  = 4'd1;
  localparam logic [3:0] ST_SCAN_CMP = 4'd2;
  localparam logic [3:0] ST_DECIDE   = 4'd3;
  localparam logic [3:0] ST_HOLD     = 4'd4;
  localparam logic [3:0] ST_WGT      = 4'd5;
  localparam logic [3:0] ST_MAC_RD   = 4'd6;
  localparam logic [3:0] ST_MAC_ACC  = 4'd7;
  localparam logic [3:0] ST_OUT      = 4'd8;

  // configuration
  mode_e       mode_q;
  logic [63:0] static_xy_q, static_zw_q, default_xy_q, default_zw_q;
  logic [2:0]  reg_idx;
  logic        cfg_wr;

  // control
  logic [3:0]    state_q, state_d;
  logic [CW-1:0] key_count_q, key_count_d;
  logic          use_static_q, use_static_d;
  logic [CW-1:0] k2_q, k2_d;
  logic [IW-1:0] k1_q, k1_d;
  logic          have1_q, have1_d, have2_q, have2_d;
  logic [1:0]    op_q, op_d;
  logic          done_q, done_d;

  // payload
  logic signed [31:0] t_q, istart_q, iend_q, t1_q, t2_q;
  kti_out_t           res_q, res_d;

  logic          accept;
  logic          wr_en;
  key_t          wr_key;
  logic [IW-1:0] rd_addr;
  key_t          rd_key;
  logic          hit1, hit2, blend;
  logic signed [32:0] num_w, den_w;
  wgt_req_t      wreq;
  logic          w_done;
  weight_t       wts [4];
  lane_ctl_t     lctl;
  logic [127:0]  op_word;
  logic [31:0]   lane_res [4];

  assign pready  = 1'b1;
  assign reg_idx = paddr[5:3];
  assign cfg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_STEP;
      static_xy_q  <= '0;
      static_zw_q  <= '0;
      default_xy_q <= '0;
      default_zw_q <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MODE:       mode_q       <= mode_e'(pwdata[1:0]);
        REG_STATIC_XY:  static_xy_q  <= pwdata;
        REG_STATIC_ZW:  static_zw_q  <= pwdata;
        REG_DEFAULT_XY: default_xy_q <= pwdata;
        REG_DEFAULT_ZW: default_zw_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:       prdata = {62'd0, mode_q};
      REG_STATIC_XY:  prdata = static_xy_q;
      REG_STATIC_ZW:  prdata = static_zw_q;
      REG_DEFAULT_XY: prdata = default_xy_q;
      REG_DEFAULT_ZW: prdata = default_zw_q;
      default:        prdata = '0;
    endcase
  end

  assign busy   = (state_q != ST_IDLE);
  assign accept = start && !busy;

  assign wr_en = accept && (item_i.command == CMD_APPEND) &&
                 (key_count_q < CW'(MAX_KEYS));
  assign wr_key.key_time = item_i.sample_time;
  assign wr_key.value    = {item_i.value_zw, item_i.value_xy};
  assign wr_key.in_tan   = {item_i.in_tan_zw, item_i.in_tan_xy};
  assign wr_key.out_tan  = {item_i.out_tan_zw, item_i.out_tan_xy};

  always_comb begin
    unique case (state_q)
      ST_DECIDE: rd_addr = k1_q;
      ST_MAC_RD: rd_addr = (op_q < 2'd2) ? k1_q : k2_q[IW-1:0];
      default:   rd_addr = k2_q[IW-1:0];
    endcase
  end

  kti_key_store #(
    .MAX_KEYS (MAX_KEYS)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (key_count_q[IW-1:0]),
    .wr_key_i  (wr_key),
    .rd_addr_i (rd_addr),
    .rd_key_o  (rd_key)
  );

  // first key dropped before the interval, second key after it
  assign hit1  = have1_q && !(t1_q < istart_q);
  assign hit2  = have2_q && !(t2_q > iend_q);
  assign blend = hit2 && (t1_q < t2_q) && (mode_q != MODE_STEP);
  assign num_w = 33'(t_q) - 33'(t1_q);
  assign den_w = 33'(t2_q) - 33'(t1_q);

  assign wreq.start = (state_q == ST_DECIDE) && hit1 && blend;
  assign wreq.num   = num_w[31:0];
  assign wreq.den   = den_w[31:0];
  assign wreq.mode  = mode_q;

  kti_weight_unit u_weight (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (wreq),
    .done_o   (w_done),
    .weight_o (wts)
  );

  assign lctl.clr = (state_q == ST_DECIDE);
  assign lctl.en  = (state_q == ST_MAC_ACC);
  assign lctl.wt  = wts[op_q];

  always_comb begin
    case (op_q)
      2'd1:    op_word = rd_key.out_tan;
      2'd2:    op_word = rd_key.in_tan;
      default: op_word = rd_key.value;
    endcase
  end

  for (genvar c = 0; c < 4; c++) begin : g_lane
    kti_lane u_lane (
      .clk_i     (clk_i),
      .ctl_i     (lctl),
      .operand_i ($signed(op_word[32*c +: 32])),
      .result_o  (lane_res[c])
    );
  end

  always_comb begin
    state_d      = state_q;
    key_count_d  = key_count_q;
    use_static_d = use_static_q;
    k1_d         = k1_q;
    k2_d         = k2_q;
    have1_d      = have1_q;
    have2_d      = have2_q;
    op_d         = op_q;
    done_d       = 1'b0;
    res_d        = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (item_i.command)
            CMD_CLEAR: begin
              key_count_d  = '0;
              use_static_d = 1'b1;
            end
            CMD_APPEND: begin
              if (wr_en) begin
                key_count_d  = key_count_q + CW'(1);
                use_static_d = 1'b0;
              end
            end
            CMD_EVAL: begin
              if (use_static_q) begin
                res_d  = '{result_xy: static_xy_q, result_zw: static_zw_q,
                           source: SRC_STATIC};
                done_d = 1'b1;
              end else begin
                state_d = ST_SCAN_RD;
                k2_d    = '0;
                have1_d = 1'b0;
                have2_d = 1'b0;
              end
            end
            default: ;
          endcase
        end
      end
      ST_SCAN_RD: begin
        state_d = (k2_q == key_count_q) ? ST_DECIDE : ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (!(t_q < rd_key.key_time)) begin
          k1_d    = k2_q[IW-1:0];
          have1_d = 1'b1;
          k2_d    = k2_q + CW'(1);
          state_d = ST_SCAN_RD;
        end else begin
          have2_d = 1'b1;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (!hit1) begin
          res_d   = '{result_xy: default_xy_q, result_zw: default_zw_q,
                      source: SRC_DEFAULT};
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else if (!blend) begin
          state_d = ST_HOLD;
        end else begin
          state_d = ST_WGT;
        end
      end
      ST_HOLD: begin
        res_d   = '{result_xy: rd_key.value[63:0], result_zw: rd_key.value[127:64],
                    source: SRC_HELD};
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      ST_WGT: begin
        if (w_done) begin
          op_d    = '0;
          state_d = ST_MAC_RD;
        end
      end
      ST_MAC_RD: state_d = ST_MAC_ACC;
      ST_MAC_ACC: begin
        op_d    = op_q + 2'd1;
        state_d = (op_q == 2'd3) ? ST_OUT : ST_MAC_RD;
      end
      ST_OUT: begin
        // merge the four lanes into the result word
        res_d   = '{result_xy: {lane_res[1], lane_res[0]},
                    result_zw: {lane_res[3], lane_res[2]},
                    source: SRC_BLEND};
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      key_count_q  <= '0;
      use_static_q <= 1'b1;
      k1_q         <= '0;
      k2_q         <= '0;
      have1_q      <= 1'b0;
      have2_q      <= 1'b0;
      op_q         <= '0;
      done_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      key_count_q  <= key_count_d;
      use_static_q <= use_static_d;
      k1_q         <= k1_d;
      k2_q         <= k2_d;
      have1_q      <= have1_d;
      have2_q      <= have2_d;
      op_q         <= op_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if (accept) begin
      t_q      <= item_i.sample_time;
      istart_q <= item_i.interval_start;
      iend_q   <= item_i.interval_end;
    end
    if (state_q == ST_SCAN_CMP) begin
      if (!(t_q < rd_key.key_time)) begin
        t1_q <= rd_key.key_time;
      end else begin
        t2_q <= rd_key.key_time;
      end
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

/* rtl/kti_checker.sv */
// ----------------------------------------------------------------------------
// kti_checker
// Port-level checks on the keyframe track interpolator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module kti_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input kti_pkg::kti_in_t  item_i,
  input logic              busy,
  input logic              done_o,
  input kti_pkg::kti_out_t result_o
);
  import kti_pkg::*;

  // only an evaluate produces a word
  `ASSERT_NXT(a_no_word_for_update, clk_i, rst_ni, start && !busy && item_i.command != CMD_EVAL, !done_o)
  // a word lands as the block goes idle
  `ASSERT_IMP(a_word_when_idle, clk_i, rst_ni, done_o, !busy)
  // every evaluate that went busy ends with a word
  `ASSERT_IMP(a_busy_ends_in_word, clk_i, rst_ni, $fell(busy), done_o)
  // a delivered word is fully defined
  `ASSERT_IMP(a_word_known, clk_i, rst_ni, done_o, !$isunknown(result_o))

endmodule

bind keyframe_track_interpolator kti_checker u_kti_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .item_i   (item_i),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);

/* sim/keyframe_track_interpolator_tb.sv */
// ----------------------------------------------------------------------------
// keyframe_track_interpolator_tb
// Self-checking bench for the keyframe track interpolator: drives clear,
// append and evaluate words plus register writes, predicts every evaluate
// answer in a scoreboard and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module keyframe_track_interpolator_tb;
  import kti_pkg::*;

  localparam int unsigned NKEYS     = 64;
  localparam int unsigned WDOG_MAX  = 5000;
  localparam int unsigned SETTLE    = 200;  // long enough for a full blend over every key
  localparam int unsigned N_RANDOM  = 480;
  localparam logic [1:0]  CMD_UNUSED = 2'd3;

  class track_scoreboard;
    mode_e       mode;
    logic [63:0] static_xy, static_zw, default_xy, default_zw;
    longint      key_time [NKEYS];
    logic [127:0] key_val [NKEYS], key_in [NKEYS], key_out [NKEYS];
    int          key_cnt;
    bit          use_static;
    kti_out_t    pending [$];
    int          mismatches;

    function void reset();
      mode = MODE_STEP;
      static_xy = '0; static_zw = '0; default_xy = '0; default_zw = '0;
      key_cnt = 0;
      use_static = 1;
      pending.delete();
      mismatches = 0;
    endfunction

    function void set_reg(logic [2:0] idx, logic [63:0] v);
      case (idx)
        REG_MODE:       mode = mode_e'(v[1:0]);
        REG_STATIC_XY:  static_xy = v;
        REG_STATIC_ZW:  static_zw = v;
        REG_DEFAULT_XY: default_xy = v;
        REG_DEFAULT_ZW: default_zw = v;
        default: ;
      endcase
    endfunction

    function longint lane(logic [127:0] v, int c);
      logic [31:0] w;
      w = v[32*c +: 32];
      return longint'($signed(w));
    endfunction

    function longint rnd_shr(longint x, int k);
      return (x + (longint'(1) <<< (k - 1))) >>> k;
    endfunction

    function void note_word(kti_in_t it);
      kti_out_t r;
      longint t, f, f2, f3, g, one, s, wt [4];
      longint unsigned num, den;
      int k1, k2;
      bit have1, have2;
      t = longint'(it.sample_time);
      case (it.command)
        CMD_CLEAR: begin
          key_cnt = 0;
          use_static = 1;
        end
        CMD_APPEND: begin
          if (key_cnt < NKEYS) begin
            key_time[key_cnt] = t;
            key_val[key_cnt] = {it.value_zw, it.value_xy};
            key_in[key_cnt]  = {it.in_tan_zw, it.in_tan_xy};
            key_out[key_cnt] = {it.out_tan_zw, it.out_tan_xy};
            key_cnt++;
            use_static = 0;
          end
        end
        CMD_EVAL: begin
          if (use_static) begin
            r = '{static_xy, static_zw, SRC_STATIC};
          end else begin
            have1 = 0; k1 = 0; k2 = 0;
            while (k2 < key_cnt && !(t < key_time[k2])) begin
              k1 = k2; have1 = 1; k2++;
            end
            have2 = k2 < key_cnt;
            if (have1 && key_time[k1] < longint'(it.interval_start)) have1 = 0;
            if (have2 && key_time[k2] > longint'(it.interval_end)) have2 = 0;
            if (!have1) begin
              r = '{default_xy, default_zw, SRC_DEFAULT};
            end else if (!have2 || key_time[k1] >= key_time[k2] || mode == MODE_STEP) begin
              r = '{key_val[k1][63:0], key_val[k1][127:64], SRC_HELD};
            end else begin
              num = longint'(t - key_time[k1]);
              den = longint'(key_time[k2] - key_time[k1]);
              f = longint'((num << 16) / den);
              f2 = f * f; f3 = f2 * f; g = 65536 - f;
              one = longint'(1) <<< 48;
              case (mode)
                MODE_LINEAR: begin
                  wt[0] = g; wt[1] = 0; wt[2] = 0; wt[3] = f;
                end
                MODE_HERMITE: begin
                  wt[0] = rnd_shr(2 * f3 - 3 * f2 * 65536 + one, 32);
                  wt[1] = rnd_shr(f3 - 2 * f2 * 65536 + f * (longint'(1) <<< 32), 32);
                  wt[2] = rnd_shr(f3 - f2 * 65536, 32);
                  wt[3] = rnd_shr(3 * f2 * 65536 - 2 * f3, 32);
                end
                default: begin
                  wt[0] = rnd_shr(g * g * g, 32);
                  wt[1] = rnd_shr(3 * f * g * g, 32);
                  wt[2] = rnd_shr(3 * f2 * g, 32);
                  wt[3] = rnd_shr(f3, 32);
                end
              endcase
              r.source = SRC_BLEND;
              for (int c = 0; c < 4; c++) begin
                s = lane(key_val[k1], c) * wt[0] + lane(key_out[k1], c) * wt[1]
                  + lane(key_in[k2], c) * wt[2] + lane(key_val[k2], c) * wt[3];
                s = rnd_shr(s, 16);
                if (s > 64'sd2147483647) s = 64'sd2147483647;
                if (s < -64'sd2147483648) s = -64'sd2147483648;
                if (c < 2) r.result_xy[32*c +: 32] = s[31:0];
                else       r.result_zw[32*(c-2) +: 32] = s[31:0];
              end
            end
          end
          pending.insert(pending.size(), r);
        end
        default: ;  // unused code
      endcase
    endfunction

    function void check_word(kti_out_t got);
      kti_out_t exp_w;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result word: xy=%h zw=%h src=%0d",
                   got.result_xy, got.result_zw, got.source);
        return;
      end
      exp_w = pending.pop_front();
      if (got.result_xy !== exp_w.result_xy || got.result_zw !== exp_w.result_zw ||
          got.source !== exp_w.source) begin
        mismatches++;
        if (mismatches <= 10)
          $display("result mismatch: exp xy=%h zw=%h src=%0d, got xy=%h zw=%h src=%0d",
                   exp_w.result_xy, exp_w.result_zw, exp_w.source,
                   got.result_xy, got.result_zw, got.source);
      end
    endfunction
  endclass

  logic        clk_i = 0;
  logic        rst_ni;
  logic        start;
  kti_in_t     item_i;
  logic        busy, done_o;
  kti_out_t    result_o;
  logic        psel, penable, pwrite;
  logic [5:0]  paddr;
  logic [63:0] pwdata, prdata;
  logic        pready;

  track_scoreboard sb = new();
  int idle_pct;
  int n_sent;
  int unsigned wdog;

  keyframe_track_interpolator #(.MAX_KEYS(NKEYS)) DUT (
    .clk_i, .rst_ni, .start, .item_i, .busy, .done_o, .result_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) sb.check_word(result_o);
  end

  // watchdog: cycles with no word taken in either direction
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_MAX) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic send_word(kti_in_t it);
    @(negedge clk_i);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(negedge clk_i);
    end
    start <= 1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    sb.note_word(it);
    n_sent++;
  endtask

  // drop start, wait for all answers, then let a running scan finish
  task automatic drain();
    @(negedge clk_i);
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] v);
    @(negedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 3'b000}; pwdata <= v;
    @(negedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, v);
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
  endtask

  function automatic logic [63:0] rnd64();
    return {$urandom(), $urandom()};
  endfunction

  // two Q16.16 lanes within +-8.0, so blends rarely saturate
  function automatic logic [63:0] modest64();
    logic [31:0] a, b;
    a = $urandom_range(0, 1 << 20) - (1 << 19);
    b = $urandom_range(0, 1 << 20) - (1 << 19);
    return {a, b};
  endfunction

  function automatic kti_in_t mk_key(int tm, bit wild);
    kti_in_t it;
    it.command = CMD_APPEND;
    it.sample_time = tm;
    it.interval_start = $urandom();
    it.interval_end = $urandom();
    it.value_xy   = wild ? rnd64() : modest64();
    it.value_zw   = wild ? rnd64() : modest64();
    it.in_tan_xy  = wild ? rnd64() : modest64();
    it.in_tan_zw  = wild ? rnd64() : modest64();
    it.out_tan_xy = wild ? rnd64() : modest64();
    it.out_tan_zw = wild ? rnd64() : modest64();
    return it;
  endfunction

  function automatic kti_in_t mk_cmd(cmd_e c, int tm, int lo, int hi);
    kti_in_t it;
    it = '{default: '0};
    it.command = c;
    it.sample_time = tm;
    it.interval_start = lo;
    it.interval_end = hi;
    it.value_xy = rnd64();
    it.value_zw = rnd64();
    it.in_tan_xy = rnd64();
    it.in_tan_zw = rnd64();
    it.out_tan_xy = rnd64();
    it.out_tan_zw = rnd64();
    return it;
  endfunction

  task automatic new_settings(mode_e m);
    write_reg(REG_MODE, m);
    write_reg(REG_STATIC_XY, rnd64());
    write_reg(REG_STATIC_ZW, rnd64());
    write_reg(REG_DEFAULT_XY, rnd64());
    write_reg(REG_DEFAULT_ZW, rnd64());
  endtask

  // a clear (usually), a run of keys, queries around them, sometimes a stray word
  task automatic key_sequence();
    int n, base, tm, first_t, last_t, q, lo, hi;
    bit wild, unsorted;
    kti_in_t junk;
    n = ($urandom_range(29) == 0) ? NKEYS + 2 : $urandom_range(1, 6);
    base = $urandom_range(0, 1 << 31) - (1 << 30);
    wild = $urandom_range(3) == 0;
    unsorted = $urandom_range(7) == 0;
    if ($urandom_range(9) != 0) send_word(mk_cmd(CMD_CLEAR, $urandom(), $urandom(), $urandom()));
    tm = base; first_t = base; last_t = base;
    for (int i = 0; i < n; i++) begin
      send_word(mk_key(tm, wild));
      last_t = tm;
      tm = unsorted ? base + $urandom_range(0, 3000) : tm + $urandom_range(0, 1000);
    end
    for (int i = $urandom_range(2, 6); i > 0; i--) begin
      q = first_t - 40 + $urandom_range(0, last_t - first_t + 80);
      lo = -32'sd2147483648; hi = 32'sd2147483647;
      if ($urandom_range(3) == 0) begin
        lo = q - $urandom_range(0, 1500);
        hi = q + $urandom_range(0, 1500);
      end
      send_word(mk_cmd(CMD_EVAL, q, lo, hi));
    end
    if ($urandom_range(4) == 0) begin
      junk = mk_cmd(CMD_CLEAR, $urandom(), $urandom(), $urandom());
      junk.command = 2'($urandom_range(0, 3));
      if (junk.command == CMD_CLEAR && $urandom_range(1)) junk.command = CMD_UNUSED;
      send_word(junk);
    end
  endtask

  initial begin
    rst_ni = 0; start = 0; item_i = '0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    sb.reset();
    idle_pct = 0; n_sent = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    write_reg(REG_MODE, MODE_LINEAR);
    write_reg(REG_STATIC_XY, 64'h7fffffff_80000000);
    write_reg(REG_STATIC_ZW, 64'hffffffff_00000000);
    write_reg(REG_DEFAULT_XY, 64'h80000000_7fffffff);
    write_reg(REG_DEFAULT_ZW, 64'h00000001_fffffffe);

    // directed: static answer, default, held, blend, interval drops, equal times
    send_word(mk_cmd(CMD_EVAL, 0, 0, 0));
    send_word(mk_cmd(cmd_e'(CMD_UNUSED), -1, -1, -1));
    send_word(mk_key(-32'sd2147483648, 0));
    send_word(mk_key(0, 1));
    send_word(mk_key(1000, 0));
    send_word(mk_key(1000, 0));
    send_word(mk_key(32'sd2147483647, 1));
    send_word(mk_cmd(CMD_EVAL, -32'sd2147483648, -32'sd2147483648, 32'sd2147483647));
    send_word(mk_cmd(CMD_EVAL, 500, -32'sd2147483648, 32'sd2147483647));
    send_word(mk_cmd(CMD_EVAL, 999, 0, 999));
    send_word(mk_cmd(CMD_EVAL, 500, 1, 32'sd2147483647));
    send_word(mk_cmd(CMD_EVAL, 1000, 0, 32'sd2147483647));
    send_word(mk_cmd(CMD_EVAL, 32'sd2147483647, 0, 32'sd2147483647));
    send_word(mk_cmd(CMD_EVAL, -7, -32'sd2147483648, 32'sd2147483647));
    send_word(mk_cmd(CMD_CLEAR, 0, 0, 0));
    send_word(mk_cmd(CMD_EVAL, 3, 0, 0));
    send_word(mk_key(-5, 1));
    send_word(mk_cmd(CMD_EVAL, -6, -32'sd2147483648, 32'sd2147483647));
    drain();
    write_reg(REG_MODE, MODE_HERMITE);
    send_word(mk_key(5, 1));
    send_word(mk_cmd(CMD_EVAL, 0, -32'sd2147483648, 32'sd2147483647));
    drain();
    write_reg(REG_MODE, MODE_BEZIER);
    send_word(mk_cmd(CMD_EVAL, 0, -32'sd2147483648, 32'sd2147483647));
    drain();
    write_reg(REG_MODE, MODE_STEP);
    send_word(mk_cmd(CMD_EVAL, 0, -32'sd2147483648, 32'sd2147483647));
    drain();

    // random part in three idle phases, settings changed between blocks
    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 8 : (ph == 1) ? 61 : 0;
      for (int blk = 0; blk < 4; blk++) begin
        new_settings(mode_e'($urandom_range(0, 3)));
        for (int base_n = n_sent; n_sent - base_n < N_RANDOM / 12; ) key_sequence();
        drain();
      end
    end

    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
